// ===== src/srpg_pkg.sv =====
// Shared types, widths, register indexes and reset constants for the stepper ramp generator.
// Used by every module of the block; depends on nothing.
package srpg_pkg;

    localparam int STEP_COUNT_BITS = 20;
    localparam int DELAY_W         = 4;
    localparam int RAMP_LEN_W      = 20;
    localparam int RAMP_INT_W      = 10;
    localparam int DIR_W           = 4;
    localparam int MODE_W          = 3;
    localparam int CFG_DATA_W      = 20;
    localparam int CFG_IDX_W       = 3;
    localparam int CMP_W           = (STEP_COUNT_BITS > RAMP_LEN_W) ? STEP_COUNT_BITS
                                                                    : RAMP_LEN_W;

    localparam logic [DELAY_W-1:0]    START_DELAY_RST   = 4'd8;
    localparam logic [DELAY_W-1:0]    SLOWEST_DELAY_RST = 4'd8;
    localparam logic [DELAY_W-1:0]    FASTEST_DELAY_RST = 4'd1;
    localparam logic [RAMP_LEN_W-1:0] RAMP_LENGTH_RST   = 20'd1600;
    localparam logic [RAMP_INT_W-1:0] RAMP_INTERVAL_RST = 10'd200;
    localparam logic [DELAY_W-1:0]    PERIOD_RST        = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_DELAY   = 3'd0,
        CFG_SLOWEST_DELAY = 3'd1,
        CFG_FASTEST_DELAY = 3'd2,
        CFG_RAMP_LENGTH   = 3'd3,
        CFG_RAMP_INTERVAL = 3'd4
    } cfg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_KEEP0 = 3'd0,
        MODE_LEFT  = 3'd1,
        MODE_RIGHT = 3'd2,
        MODE_ALT_A = 3'd3,
        MODE_ALT_B = 3'd4,
        MODE_ALL0  = 3'd5,
        MODE_ALL1  = 3'd6,
        MODE_KEEP7 = 3'd7
    } mode_t;

    typedef struct packed {
        logic [DELAY_W-1:0]    start_delay;
        logic [DELAY_W-1:0]    slowest_delay;
        logic [DELAY_W-1:0]    fastest_delay;
        logic [RAMP_LEN_W-1:0] ramp_length;
        logic [RAMP_INT_W-1:0] ramp_interval;
    } cfg_t;

    typedef struct packed {
        logic                       action;
        logic [MODE_W-1:0]          mode;
        logic [STEP_COUNT_BITS-1:0] step_count;
    } item_t;

    typedef struct packed {
        logic               step_level;
        logic [DIR_W-1:0]   directions;
        logic               busy_res;
        logic [DELAY_W-1:0] period_now;
        logic               finished;
    } res_t;

    // Direction pattern for a start; modes outside 1..6 keep the old bits.
    function automatic logic [DIR_W-1:0] dir_pattern(input logic [MODE_W-1:0] mode,
                                                     input logic [DIR_W-1:0]  prev);
        logic [DIR_W-1:0] d;
        begin
            case (mode)
                MODE_LEFT:  d = 4'b1100;
                MODE_RIGHT: d = 4'b0011;
                MODE_ALT_A: d = 4'b0101;
                MODE_ALT_B: d = 4'b1010;
                MODE_ALL0:  d = 4'b0000;
                MODE_ALL1:  d = 4'b1111;
                default:    d = prev;
            endcase
            return d;
        end
    endfunction

endpackage

// ===== src/stepper_ramp_pulse_generator.sv =====
// Stepper ramp generator top: input word register, move state update, result register.
// Depends on srpg_pkg, srpg_cfg and srpg_core.
// An accepted input word passes the input register, then the result register, to the output.
// Throughput: one word per cycle unless res_ready stalls; the state update is a single pass
// between the input register and the result register.
// Reset: asynchronous, active low; clears the pipeline, move state and loads config defaults.
module stepper_ramp_pulse_generator (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    item_valid,
    output logic                                    item_ready,
    input  logic                                    action,
    input  logic [srpg_pkg::MODE_W-1:0]             mode,
    input  logic [srpg_pkg::STEP_COUNT_BITS-1:0]    step_count,
    output logic                                    res_valid,
    input  logic                                    res_ready,
    output logic                                    step_level,
    output logic [srpg_pkg::DIR_W-1:0]              directions,
    output logic                                    busy_res,
    output logic [srpg_pkg::DELAY_W-1:0]            period_now,
    output logic                                    finished,
    input  logic                                    cfg_we,
    input  logic [srpg_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [srpg_pkg::CFG_DATA_W-1:0]         cfg_data
);

    srpg_pkg::cfg_t  cfg;
    srpg_pkg::item_t stage_reg;
    logic            stage_vld_reg;
    srpg_pkg::res_t  res_comb;
    srpg_pkg::res_t  res_reg;
    logic            res_vld_reg;
    logic            advance;
    logic            take;

    // stage word moves into the result register when that slot is free or draining
    assign advance    = stage_vld_reg && (!res_vld_reg || res_ready);
    assign item_ready = !stage_vld_reg || advance;
    assign take       = item_valid && item_ready;

    srpg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srpg_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (advance),
        .item   (stage_reg),
        .cfg    (cfg),
        .res    (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
            res_vld_reg   <= 1'b0;
        end
        else
        begin
            if (take)
                stage_vld_reg <= 1'b1;
            else if (advance)
                stage_vld_reg <= 1'b0;

            if (advance)
                res_vld_reg <= 1'b1;
            else if (res_ready)
                res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_reg.action     <= action;
            stage_reg.mode       <= mode;
            stage_reg.step_count <= step_count;
        end
        if (advance)
            res_reg <= res_comb;
    end

    assign res_valid  = res_vld_reg;
    assign step_level = res_reg.step_level;
    assign directions = res_reg.directions;
    assign busy_res   = res_reg.busy_res;
    assign period_now = res_reg.period_now;
    assign finished   = res_reg.finished;

    a_fin_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && res_reg.finished |-> !res_reg.busy_res)
        else $error("finished word reports busy");

    a_take_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> stage_vld_reg)
        else $error("accepted word lost from input register");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        stage_vld_reg && !advance |=> stage_vld_reg && $stable(stage_reg))
        else $error("stalled input register changed");

    a_advance_fills_res: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_vld_reg)
        else $error("result register not filled after advance");

endmodule

// ===== src/srpg_cfg.sv =====
// Configuration register file of the stepper ramp generator.
// Depends on srpg_pkg for the register indexes and reset values.
module srpg_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [srpg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srpg_pkg::CFG_DATA_W-1:0]     cfg_data,
    output srpg_pkg::cfg_t                      cfg
);

    srpg_pkg::cfg_t cfg_reg;
    srpg_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                srpg_pkg::CFG_START_DELAY:
                    cfg_next.start_delay   = cfg_data[srpg_pkg::DELAY_W-1:0];
                srpg_pkg::CFG_SLOWEST_DELAY:
                    cfg_next.slowest_delay = cfg_data[srpg_pkg::DELAY_W-1:0];
                srpg_pkg::CFG_FASTEST_DELAY:
                    cfg_next.fastest_delay = cfg_data[srpg_pkg::DELAY_W-1:0];
                srpg_pkg::CFG_RAMP_LENGTH:
                    cfg_next.ramp_length   = cfg_data[srpg_pkg::RAMP_LEN_W-1:0];
                srpg_pkg::CFG_RAMP_INTERVAL:
                    cfg_next.ramp_interval = cfg_data[srpg_pkg::RAMP_INT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_delay   <= srpg_pkg::START_DELAY_RST;
            cfg_reg.slowest_delay <= srpg_pkg::SLOWEST_DELAY_RST;
            cfg_reg.fastest_delay <= srpg_pkg::FASTEST_DELAY_RST;
            cfg_reg.ramp_length   <= srpg_pkg::RAMP_LENGTH_RST;
            cfg_reg.ramp_interval <= srpg_pkg::RAMP_INTERVAL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/srpg_core.sv =====
// Move state of the stepper ramp generator and its single-pass update for one word.
// Depends on srpg_pkg for types, widths and the direction pattern function.
module srpg_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           update,
    input  srpg_pkg::item_t item,
    input  srpg_pkg::cfg_t  cfg,
    output srpg_pkg::res_t  res
);

    localparam int SCB = srpg_pkg::STEP_COUNT_BITS;
    localparam int CW  = srpg_pkg::CMP_W;
    localparam int DW  = srpg_pkg::DELAY_W;
    localparam int RIW = srpg_pkg::RAMP_INT_W;

    logic                        running_reg, running_next;
    logic [SCB-1:0]              target_reg, target_next;
    logic [SCB-1:0]              done_reg, done_next;
    logic [DW-1:0]               tick_reg, tick_next;
    logic [RIW-1:0]              ramp_cnt_reg, ramp_cnt_next;
    logic [DW-1:0]               period_reg, period_next;
    logic                        level_reg, level_next;
    logic [srpg_pkg::DIR_W-1:0]  dir_reg, dir_next;
    logic                        fin;

    logic [DW-1:0]  tick_inc;
    logic [SCB-1:0] done_inc;
    logic [SCB-1:0] remaining;
    logic           at_end;
    logic           decel;
    logic           accel;
    logic [RIW-1:0] ramp_inc;
    logic           ramp_due;
    logic [DW:0]    period_up;
    logic [DW-1:0]  period_dn;

    always_comb
    begin
        tick_inc  = tick_reg + 1'b1;
        done_inc  = done_reg + 1'b1;
        remaining = target_reg - done_inc;
        at_end    = (done_inc >= target_reg);
        decel     = at_end || (CW'(remaining) < CW'(cfg.ramp_length));
        accel     = !decel && (CW'(done_inc) < CW'(cfg.ramp_length));
        ramp_inc  = ramp_cnt_reg + 1'b1;
        ramp_due  = (ramp_inc >= cfg.ramp_interval);

        period_up = {1'b0, period_reg} + 1'b1;
        if (period_up > {1'b0, cfg.slowest_delay})
            period_up = {1'b0, cfg.slowest_delay};
        period_dn = (period_reg == '0) ? '0 : period_reg - 1'b1;
        if (period_dn < cfg.fastest_delay)
            period_dn = cfg.fastest_delay;

        running_next  = running_reg;
        target_next   = target_reg;
        done_next     = done_reg;
        tick_next     = tick_reg;
        ramp_cnt_next = ramp_cnt_reg;
        period_next   = period_reg;
        level_next    = level_reg;
        dir_next      = dir_reg;
        fin           = 1'b0;

        if (item.action)
        begin
            // start or restart: counters survive a restart, but the done count clears for a zero step_count
            dir_next    = srpg_pkg::dir_pattern(item.mode, dir_reg);
            target_next = item.step_count;
            period_next = cfg.start_delay;
            if (item.step_count == '0)
            begin
                running_next = 1'b0;
                done_next    = '0;
                fin          = 1'b1;
            end
            else
            begin
                running_next = 1'b1;
            end
        end
        else if (running_reg)
        begin
            tick_next = tick_inc;
            if (tick_inc >= period_reg)
            begin
                tick_next  = '0;
                level_next = !level_reg;
                done_next  = done_inc;
                if (decel || accel)
                begin
                    ramp_cnt_next = ramp_due ? '0 : ramp_inc;
                    if (ramp_due)
                        period_next = decel ? period_up[DW-1:0] : period_dn;
                end
                if (at_end)
                begin
                    done_next    = '0;
                    running_next = 1'b0;
                    fin          = 1'b1;
                end
            end
        end

        res.step_level = level_next;
        res.directions = dir_next;
        res.busy_res   = running_next;
        res.period_now = period_next;
        res.finished   = fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg  <= 1'b0;
            target_reg   <= '0;
            done_reg     <= '0;
            tick_reg     <= '0;
            ramp_cnt_reg <= '0;
            period_reg   <= srpg_pkg::PERIOD_RST;
            level_reg    <= 1'b0;
            dir_reg      <= '0;
        end
        else if (update)
        begin
            running_reg  <= running_next;
            target_reg   <= target_next;
            done_reg     <= done_next;
            tick_reg     <= tick_next;
            ramp_cnt_reg <= ramp_cnt_next;
            period_reg   <= period_next;
            level_reg    <= level_next;
            dir_reg      <= dir_next;
        end
    end

endmodule
